// ===== design/tpac_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpac_pkg: shared types and codes
// Item kinds, position modes, register indexes and the configuration struct
// of the two-position actuator controller.
// ----------------------------------------------------------------------------
package tpac_pkg;

  localparam int KIND_W = 2;
  localparam int MODE_W = 2;
  localparam int SPEED_W = 15;
  localparam int VEL_W = 16;
  localparam int TIMEOUT_W = 16;
  localparam int BLINK_W = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_TICK      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SHIFT_IN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SHIFT_OUT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_HOME      = 2'd3;

  // position modes
  localparam logic [MODE_W-1:0] MODE_UNKNOWN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HOMING   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INBOUND  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_OUTBOUND = 2'd3;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_SPEED    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOME_SPEED     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION_FLIP = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HOME_TIMEOUT   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BLINK_PERIOD   = 3'd4;

  typedef struct packed {
    logic [SPEED_W-1:0]   drive_speed;
    logic [SPEED_W-1:0]   home_speed;
    logic                 direction_flip;
    logic [TIMEOUT_W-1:0] home_timeout_ticks;
    logic [BLINK_W-1:0]   blink_period;
  } cfg_t;

  typedef struct packed {
    logic              motor_enable;
    logic [VEL_W-1:0]  motor_velocity;
    logic [VEL_W-1:0]  velocity_target;
    logic              led_on;
    logic [MODE_W-1:0] position_mode;
    logic              home_failed;
  } result_t;

  // motor runs while homing, or toward a target stop whose switch is open
  function automatic logic drives(input logic [MODE_W-1:0] mode,
                                  input logic inb, input logic outb);
    logic d;
    case (mode)
      MODE_HOMING:   d = 1'b1;
      MODE_INBOUND:  d = ~inb;
      MODE_OUTBOUND: d = ~outb;
      default:       d = 1'b0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== design/tpac_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpac_in_if / tpac_out_if: valid-ready channels
// Request channel carries kind and switch levels; result channel carries the
// drive command, LED level and status.
// ----------------------------------------------------------------------------
interface tpac_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic       inbound_closed;
  logic       outbound_closed;

  modport source (output valid, output kind, output inbound_closed,
                  output outbound_closed, input ready);
  modport sink (input valid, input kind, input inbound_closed,
                input outbound_closed, output ready);
endinterface

interface tpac_out_if;
  logic               valid;
  logic               ready;
  logic               motor_enable;
  logic signed [15:0] motor_velocity;
  logic signed [15:0] velocity_target;
  logic               led_on;
  logic [1:0]         position_mode;
  logic               home_failed;

  modport source (output valid, output motor_enable, output motor_velocity,
                  output velocity_target, output led_on, output position_mode,
                  output home_failed, input ready);
  modport sink (input valid, input motor_enable, input motor_velocity,
                input velocity_target, input led_on, input position_mode,
                input home_failed, output ready);
endinterface
`default_nettype wire

// ===== design/two_position_actuator_control.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// two_position_actuator_control: end-stop actuator controller
// Homing, inbound/outbound shifting and status LED for a motor between two
// limit switches.
// ----------------------------------------------------------------------------
// Each request word (tick, shift in, shift out, start homing, plus the two
// switch levels) yields exactly one result word holding the motor enable,
// signed velocity with and without the direction sign, LED level, position
// mode and homing-failed flag for the state after that word. One word is
// accepted every clock cycle unless the sink stalls with both stages full; a
// word is held in the input register and its result is captured from there
// into the output register. The rate is set by the state update in tpac_core,
// which reads and writes the mode and counters once per word. The
// output register holds a result while the sink stalls, and the input
// register keeps taking words until both stages are full. Configuration
// writes take effect on the next edge and must be made while the block is
// idle.
// ----------------------------------------------------------------------------
module two_position_actuator_control (
  input  wire logic                             clk,
  input  wire logic                             rst,
  tpac_in_if.sink                               in_ch,
  tpac_out_if.source                            out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [tpac_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tpac_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tpac_pkg::*;

  cfg_t    cfg;
  result_t res;

  // input register
  logic              s1_valid;
  logic [KIND_W-1:0] s1_kind;
  logic              s1_inb;
  logic              s1_outb;
  logic              s1_advance;

  // output register
  logic    out_valid;
  result_t out_res;

  tpac_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // advance the held word into the output register when that slot frees up
  assign s1_advance  = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  // payload needs no reset; load only on accept
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_kind <= in_ch.kind;
      s1_inb  <= in_ch.inbound_closed;
      s1_outb <= in_ch.outbound_closed;
    end
  end

  // state commits exactly when the word's result is captured
  tpac_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (s1_advance),
    .kind (s1_kind),
    .inb  (s1_inb),
    .outb (s1_outb),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) out_res <= res;
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.motor_enable    = out_res.motor_enable;
  assign out_ch.motor_velocity  = out_res.motor_velocity;
  assign out_ch.velocity_target = out_res.velocity_target;
  assign out_ch.led_on          = out_res.led_on;
  assign out_ch.position_mode   = out_res.position_mode;
  assign out_ch.home_failed     = out_res.home_failed;

  // a word moved out of the input register always lands as a valid result
  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> out_valid)
    else $error("advanced word did not reach the output register");

  // a stalled result must not be overwritten by the input register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |-> !s1_advance)
    else $error("stalled result overwritten");

  // idle motor means zero velocity on both fields
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.motor_enable |->
      out_ch.motor_velocity == '0 && out_ch.velocity_target == '0)
    else $error("velocity nonzero while motor idle");

  // homing always drives and never carries a stale failure
  a_homing_drives: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ch.position_mode == MODE_HOMING |->
      out_ch.motor_enable && !out_ch.home_failed)
    else $error("homing result inconsistent");

  // direction sign applied consistently
  a_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && !cfg.direction_flip |->
      out_ch.motor_velocity == out_ch.velocity_target)
    else $error("motor velocity sign mismatch");

endmodule
`default_nettype wire

// ===== design/tpac_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpac_cfg_regs: configuration registers
// Write-only register file; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module tpac_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [tpac_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tpac_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output tpac_pkg::cfg_t                        cfg
);
  import tpac_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_speed        <= 15'd2560;
      cfg.home_speed         <= 15'd1280;
      cfg.direction_flip     <= 1'b0;
      cfg.home_timeout_ticks <= 16'd2000;
      cfg.blink_period       <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DRIVE_SPEED:    cfg.drive_speed        <= cfg_wdata[SPEED_W-1:0];
        REG_HOME_SPEED:     cfg.home_speed         <= cfg_wdata[SPEED_W-1:0];
        REG_DIRECTION_FLIP: cfg.direction_flip     <= cfg_wdata[0];
        REG_HOME_TIMEOUT:   cfg.home_timeout_ticks <= cfg_wdata[TIMEOUT_W-1:0];
        REG_BLINK_PERIOD:   cfg.blink_period       <= cfg_wdata[BLINK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/tpac_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpac_core: position state and next-state logic
// Holds mode, blink and homing counters; commits one word per step and
// presents the result for the state after that word.
// ----------------------------------------------------------------------------
module tpac_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        step,
  input  wire logic [tpac_pkg::KIND_W-1:0] kind,
  input  wire logic                        inb,
  input  wire logic                        outb,
  input  tpac_pkg::cfg_t                   cfg,
  output tpac_pkg::result_t                res
);
  import tpac_pkg::*;

  logic [MODE_W-1:0]    mode, mode_next;
  logic [BLINK_W-1:0]   blink_phase, blink_phase_next;
  logic [TIMEOUT_W-1:0] home_elapsed, home_elapsed_next;
  logic                 blink_toggle, blink_toggle_next;
  logic                 led_level, led_level_next;
  logic                 fail_flag, fail_flag_next;

  logic [BLINK_W-1:0]   period;
  logic [BLINK_W:0]     phase_inc;
  logic                 fire;
  logic [TIMEOUT_W-1:0] elapsed_inc;
  logic                 en;
  logic [VEL_W-1:0]     cmd;

  always_comb begin
    period      = (cfg.blink_period == '0) ? BLINK_W'(1) : cfg.blink_period;
    phase_inc   = {1'b0, blink_phase} + (BLINK_W+1)'(1);
    fire        = phase_inc >= {1'b0, period};
    elapsed_inc = (home_elapsed == '1) ? home_elapsed
                                       : home_elapsed + TIMEOUT_W'(1);

    mode_next         = mode;
    blink_phase_next  = blink_phase;
    home_elapsed_next = home_elapsed;
    blink_toggle_next = blink_toggle;
    led_level_next    = led_level;
    fail_flag_next    = fail_flag;

    case (kind)
      KIND_TICK: begin
        if (mode == MODE_HOMING) begin
          if (outb) begin
            mode_next         = MODE_OUTBOUND;
            blink_toggle_next = 1'b0;
            led_level_next    = 1'b0;
          end else begin
            home_elapsed_next = elapsed_inc;
            if (elapsed_inc > cfg.home_timeout_ticks) begin
              fail_flag_next = 1'b1;
              mode_next      = MODE_UNKNOWN;
            end
          end
        end else begin
          blink_phase_next = fire ? '0 : phase_inc[BLINK_W-1:0];
          if (mode == MODE_INBOUND || mode == MODE_OUTBOUND) begin
            if (drives(mode, inb, outb)) begin
              if (fire) begin
                blink_toggle_next = ~blink_toggle;
                led_level_next    = ~blink_toggle;
              end
            end else begin
              led_level_next = (mode == MODE_INBOUND);
            end
          end
        end
      end
      KIND_SHIFT_IN: begin
        if (mode != MODE_HOMING) mode_next = MODE_INBOUND;
      end
      KIND_SHIFT_OUT: begin
        if (mode != MODE_HOMING) mode_next = MODE_OUTBOUND;
      end
      KIND_HOME: begin
        home_elapsed_next = '0;
        fail_flag_next    = 1'b0;
        if (inb) begin
          mode_next         = MODE_INBOUND;
          blink_toggle_next = 1'b0;
          led_level_next    = 1'b0;
        end else begin
          mode_next         = MODE_HOMING;
          blink_toggle_next = 1'b1;
          led_level_next    = 1'b1;
        end
      end
      default: ;
    endcase

    en = drives(mode_next, inb, outb);
    case (mode_next)
      MODE_HOMING:  cmd = -{1'b0, cfg.home_speed};
      MODE_INBOUND: cmd = {1'b0, cfg.drive_speed};
      default:      cmd = -{1'b0, cfg.drive_speed};
    endcase
    if (!en) cmd = '0;

    res.motor_enable    = en;
    res.velocity_target = cmd;
    res.motor_velocity  = cfg.direction_flip ? -cmd : cmd;
    res.led_on          = led_level_next;
    res.position_mode   = mode_next;
    res.home_failed     = fail_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_UNKNOWN;
      blink_phase  <= '0;
      home_elapsed <= '0;
      blink_toggle <= 1'b0;
      led_level    <= 1'b0;
      fail_flag    <= 1'b0;
    end else if (step) begin
      mode         <= mode_next;
      blink_phase  <= blink_phase_next;
      home_elapsed <= home_elapsed_next;
      blink_toggle <= blink_toggle_next;
      led_level    <= led_level_next;
      fail_flag    <= fail_flag_next;
    end
  end

endmodule
`default_nettype wire
